### hdl/fpas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared constants and types for the single-precision add/subtract block.
// ----------------------------------------------------------------------------
package fpas_pkg;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned MANT_W = 23;
    localparam int unsigned WIDE_W = 24;
    localparam int unsigned WORD_W = 32;
    localparam logic [EXP_W-1:0] EXP_MAX = 8'd255;
    localparam logic [WORD_W-1:0] NAN_INF_CLASH = 32'h7F80_0001;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_SUB = 1'b1;

    // Aligned operands handed from the alignment stage to the normalizer.
    typedef struct packed {
        logic                special;
        logic [WORD_W-1:0]   special_word;
        logic                sign_a;
        logic                sign_b;
        logic [WIDE_W-1:0]   mant_a;
        logic [WIDE_W-1:0]   mant_b;
        logic [EXP_W-1:0]    exp;
    } t_aligned;
endpackage

### hdl/fpas_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_align
// Special-value detection and mantissa alignment to the larger exponent.
// ----------------------------------------------------------------------------
module fpas_align
    import fpas_pkg::*;
(
    input  logic              i_action,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output t_aligned          o_aligned
);
    logic [WORD_W-1:0] b_eff;
    logic [EXP_W-1:0]  ea, eb, xa, xb, diff;
    logic [WIDE_W-1:0] ua, ub;
    logic              nan_a, nan_b, inf_a, inf_b, a_big;

    always_comb begin
        b_eff = i_operand_b ^ {(i_action == ACT_SUB), {(WORD_W-1){1'b0}}};
        ea = i_operand_a[WORD_W-2:MANT_W];
        eb = b_eff[WORD_W-2:MANT_W];
        nan_a = (ea == EXP_MAX) && (i_operand_a[MANT_W-1:0] != '0);
        nan_b = (eb == EXP_MAX) && (b_eff[MANT_W-1:0] != '0);
        inf_a = (ea == EXP_MAX) && !nan_a;
        inf_b = (eb == EXP_MAX) && !nan_b;
        ua = {(ea != '0), i_operand_a[MANT_W-1:0]};
        ub = {(eb != '0), b_eff[MANT_W-1:0]};
        xa = (ea != '0) ? ea : 8'd1;
        xb = (eb != '0) ? eb : 8'd1;
        a_big = xa > xb;
        diff = a_big ? (xa - xb) : (xb - xa);

        o_aligned.sign_a = i_operand_a[WORD_W-1];
        o_aligned.sign_b = b_eff[WORD_W-1];
        o_aligned.exp    = a_big ? xa : xb;
        o_aligned.mant_a = (!a_big) ? ((diff >= 8'(WIDE_W)) ? '0 : (ua >> diff)) : ua;
        o_aligned.mant_b = a_big ? ((diff >= 8'(WIDE_W)) ? '0 : (ub >> diff)) : ub;

        o_aligned.special      = 1'b1;
        o_aligned.special_word = i_operand_a;
        if (nan_a) begin
            o_aligned.special_word = i_operand_a;
        end else if (nan_b) begin
            o_aligned.special_word = b_eff;
        end else if (inf_a) begin
            if (inf_b && (i_operand_a[WORD_W-1] != b_eff[WORD_W-1])) begin
                o_aligned.special_word = NAN_INF_CLASH;
            end
        end else if (inf_b) begin
            o_aligned.special_word = b_eff;
        end else begin
            o_aligned.special = 1'b0;
        end
    end
endmodule

### hdl/fpas_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_norm
// Signed-magnitude add, leading-zero normalization, overflow and underflow.
// ----------------------------------------------------------------------------
module fpas_norm
    import fpas_pkg::*;
(
    input  t_aligned          i_aligned,
    output logic [WORD_W-1:0] o_word
);
    logic [WIDE_W:0]   r;
    logic [WIDE_W-1:0] m, mn;
    logic              s;
    logic signed [EXP_W+1:0] e;
    logic [4:0]        lz;
    logic [5:0]        rsh;

    always_comb begin
        e = signed'({2'b00, i_aligned.exp});
        if (i_aligned.sign_a == i_aligned.sign_b) begin
            r = {1'b0, i_aligned.mant_a} + {1'b0, i_aligned.mant_b};
            s = i_aligned.sign_a;
        end else if (i_aligned.mant_a >= i_aligned.mant_b) begin
            r = {1'b0, i_aligned.mant_a - i_aligned.mant_b};
            s = (r == '0) ? 1'b0 : i_aligned.sign_a;
        end else begin
            r = {1'b0, i_aligned.mant_b - i_aligned.mant_a};
            s = i_aligned.sign_b;
        end
        if (r[WIDE_W]) begin
            m = r[WIDE_W:1];
            e = e + 10'sd1;
        end else begin
            m = r[WIDE_W-1:0];
        end
        lz = '0;
        for (int i = 0; i < WIDE_W; i++) begin
            if (m[i]) begin
                lz = 5'(WIDE_W - 1 - i);
            end
        end
        mn = m << lz;
        e = e - signed'({5'b0, lz});
        rsh = '0;

        if (i_aligned.special) begin
            o_word = i_aligned.special_word;
        end else if (m == '0) begin
            o_word = {s, {(WORD_W-1){1'b0}}};
        end else if (e >= signed'({2'b00, EXP_MAX})) begin
            o_word = {s, EXP_MAX, {MANT_W{1'b0}}};
        end else if (e <= -10'sd24) begin
            o_word = {s, {(WORD_W-1){1'b0}}};
        end else if (e <= 10'sd0) begin
            rsh = 6'(10'sd1 - e);
            o_word = {s, {EXP_W{1'b0}}, MANT_W'(mn >> rsh)};
        end else begin
            o_word = {s, e[EXP_W-1:0], mn[MANT_W-1:0]};
        end
    end
endmodule

### hdl/float32_add_subtract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_add_subtract
// Single-precision add/subtract with truncation, one operation per cycle.
// ----------------------------------------------------------------------------
// Channel   Ports                                      Handshake
// command   i_action, i_operand_a, i_operand_b        i_start & !o_busy
// result    o_sum_word                                 o_done, one cycle
//
// Each transaction is registered at the input, passes alignment and
// normalization logic, and is registered at the output; o_done and
// o_sum_word come straight from the output registers. o_busy is always
// low, so a transaction may be started on every cycle. The synchronous
// active-low reset clears the valid flags; the receiver cannot stall the
// result strobe.
module float32_add_subtract
    import fpas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_action,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_sum_word
);
    logic              r_in_vld, r_out_vld;
    logic              r_action;
    logic [WORD_W-1:0] r_a, r_b, r_sum;
    logic [WORD_W-1:0] n_sum;
    t_aligned          aligned;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_action <= i_action;
            r_a      <= i_operand_a;
            r_b      <= i_operand_b;
        end
        r_sum <= n_sum;
    end

    fpas_align u_align (
        .i_action    (r_action),
        .i_operand_a (r_a),
        .i_operand_b (r_b),
        .o_aligned   (aligned)
    );

    fpas_norm u_norm (
        .i_aligned (aligned),
        .o_word    (n_sum)
    );

    assign o_done     = r_out_vld;
    assign o_sum_word = r_sum;
endmodule

### hdl/fpas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_checker
// Port-level checks on transaction timing of the add/subtract block.
// ----------------------------------------------------------------------------
module fpas_checker
    import fpas_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input logic [WORD_W-1:0] o_sum_word
);
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_done) else $error("missing result");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 2)) else $error("spurious result");
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy asserted");
    a_sum_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_sum_word)) else $error("unknown result");
endmodule

bind float32_add_subtract fpas_checker u_fpas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .o_sum_word (o_sum_word)
);

### tb/sv/tb_float32_add_subtract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float32_add_subtract
// Self-checking bench for the truncating single-precision add/subtract unit.
// Directed operands cover NaNs, infinities, zeros, denormals, wide alignment
// shifts, cancellation, overflow and underflow. Weighted random operands
// follow, with idle gaps on the command side. Each result is compared with
// a behavioral model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_float32_add_subtract;
    import fpas_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              i_action = ACT_ADD;
    logic [WORD_W-1:0] i_operand_a = '0;
    logic [WORD_W-1:0] i_operand_b = '0;
    logic              o_busy;
    logic              o_done;
    logic [WORD_W-1:0] o_sum_word;

    float32_add_subtract dut (.*);

    always #2 i_clk = ~i_clk;

    // Expected sums, oldest first; one entry per accepted transaction.
    logic [WORD_W-1:0] sums_pending[$];
    int unsigned       error_count = 0;
    int unsigned       sums_checked = 0;
    int unsigned       idle_pct = 0;

    // Truncating add/subtract, computed from the operand fields.
    function automatic logic [WORD_W-1:0] truncated_sum(input logic act,
            input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b_in);
        logic [WORD_W-1:0] b;
        logic              sa, sb, s;
        logic [EXP_W-1:0]  ea, eb;
        logic [31:0]       ua, ub, r, d;
        int                e, xa, xb;
        b  = b_in ^ {act, 31'd0};
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        if (ea == EXP_MAX && a[22:0] != 0) return a;
        if (eb == EXP_MAX && b[22:0] != 0) return b;
        if (ea == EXP_MAX) begin
            if (eb == EXP_MAX && sa != sb) return NAN_INF_CLASH;
            return a;
        end
        if (eb == EXP_MAX) return b;
        ua = {8'd0, ea != 0, a[22:0]};
        ub = {8'd0, eb != 0, b[22:0]};
        xa = (ea != 0) ? int'(ea) : 1;
        xb = (eb != 0) ? int'(eb) : 1;
        // Align to the larger exponent; no guard bits survive the shift.
        if (xa > xb) begin
            d  = xa - xb;
            ub = (d >= WIDE_W) ? 32'd0 : ub >> d;
            e  = xa;
        end else begin
            d  = xb - xa;
            ua = (d >= WIDE_W) ? 32'd0 : ua >> d;
            e  = xb;
        end
        if (sa == sb) begin
            r = ua + ub;
            s = sa;
            if (r[24]) begin
                r = r >> 1;
                e++;
            end
        end else if (ua >= ub) begin
            r = ua - ub;
            s = (r == 0) ? 1'b0 : sa;
        end else begin
            r = ub - ua;
            s = sb;
        end
        if (r == 0) return {s, 31'd0};
        while (!r[23]) begin
            r = r << 1;
            e--;
        end
        if (e >= 255) return {s, EXP_MAX, 23'd0};
        if (e <= 0) begin
            if (e <= -24) return {s, 31'd0};
            r = r >> (1 - e);
            e = 0;
        end
        return {s, e[7:0], r[22:0]};
    endfunction

    // Sends one transaction, holding start until it is accepted.
    task automatic send_operation(input logic act, input logic [WORD_W-1:0] a,
            input logic [WORD_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_action    <= act;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sums_pending.push_back(truncated_sum(act, a, b));
        @(negedge i_clk);
    endtask

    // Every result strobe is compared with the oldest pending sum.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sums_pending.size() == 0) begin
                $display("%0t: unexpected sum, expected none, actual %h",
                         $time, o_sum_word);
                error_count++;
            end else begin
                if (o_sum_word !== sums_pending[0]) begin
                    $display("%0t: sum_word mismatch, expected %h, actual %h",
                             $time, sums_pending[0], o_sum_word);
                    error_count++;
                end
                void'(sums_pending.pop_front());
                sums_checked++;
            end
        end
    end

    // Random operand with extra weight on special exponents and mantissas.
    function automatic logic [WORD_W-1:0] random_float();
        logic [7:0]  ex;
        logic [22:0] mt;
        case ($urandom_range(7))
            0:       ex = 8'd0;
            1:       ex = EXP_MAX;
            2:       ex = 8'(254 - $urandom_range(3));
            3:       ex = 8'(1 + $urandom_range(3));
            default: ex = 8'($urandom_range(255));
        endcase
        case ($urandom_range(5))
            0:       mt = '0;
            1:       mt = '1;
            default: mt = 23'($urandom);
        endcase
        return {1'($urandom), ex, mt};
    endfunction

    task automatic test_special_values();
        send_operation(ACT_ADD, 32'h7FC0_0001, 32'hFF80_0003);
        send_operation(ACT_SUB, 32'h3F80_0000, 32'h7F80_0005);
        send_operation(ACT_SUB, 32'h7F80_0000, 32'h7F80_0000);
        send_operation(ACT_ADD, 32'hFF80_0000, 32'h7F80_0000);
        send_operation(ACT_ADD, 32'h7F80_0000, 32'h7F80_0000);
        send_operation(ACT_ADD, 32'h4000_0000, 32'hFF80_0000);
        send_operation(ACT_SUB, 32'h0000_0000, 32'h0000_0000);
        send_operation(ACT_ADD, 32'h8000_0000, 32'h8000_0000);
        send_operation(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_arithmetic_edges();
        send_operation(ACT_ADD, 32'h007F_FFFF, 32'h0000_0001);
        send_operation(ACT_SUB, 32'h0080_0000, 32'h0000_0001);
        send_operation(ACT_ADD, 32'h4B80_0000, 32'h3F80_0000);
        send_operation(ACT_ADD, 32'h4C00_0000, 32'h3F80_0000);
        send_operation(ACT_SUB, 32'h4049_0FDB, 32'h4049_0FDB);
        send_operation(ACT_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_operation(ACT_ADD, 32'hFF7F_FFFF, 32'hFF00_0000);
        send_operation(ACT_SUB, 32'h0080_0001, 32'h0080_0000);
        send_operation(ACT_SUB, 32'h3F80_0001, 32'h3F80_0000);
        send_operation(ACT_ADD, 32'h3F80_0000, 32'hBF7F_FFFF);
    endtask

    task automatic test_random_phase(input int unsigned count,
            input int unsigned pct);
        idle_pct = pct;
        repeat (count) send_operation(1'($urandom), random_float(), random_float());
        idle_pct = 0;
    endtask

    // Time limit far above the slowest legitimate run.
    initial begin
        #2_000_000;
        $display("tb_float32_add_subtract failed");
        $finish;
    end

    initial begin
        int unsigned drain;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_special_values();
        test_arithmetic_edges();
        test_random_phase(650, 0);
        test_random_phase(650, 83);
        test_random_phase(650, 18);
        i_start <= 1'b0;
        drain = 0;
        while (sums_pending.size() != 0 && drain < 1000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (5) @(negedge i_clk);
        $display("Covered special operands, edge arithmetic and %0d checked sums",
                 sums_checked);
        $display("across continuous, sparse and lightly gapped command phases.");
        if (error_count == 0 && sums_pending.size() == 0) begin
            $display("tb_float32_add_subtract passed");
        end else begin
            $display("tb_float32_add_subtract failed");
        end
        $finish;
    end
endmodule

### float32_add_subtract.f
hdl/fpas_pkg.sv
hdl/fpas_align.sv
hdl/fpas_norm.sv
hdl/float32_add_subtract.sv
hdl/fpas_checker.sv
tb/sv/tb_float32_add_subtract.sv
